FILE: src/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg
// Shared widths, reset values and parameter defaults for the radix digit
// emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int VALUE_BITS          = 32;  // width of the input value port
  localparam int DIGIT_BITS          = 6;   // width of one digit
  localparam int RADIX_BITS          = 6;   // width of the radix register
  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int DEFAULT_STACK_DEPTH = 32;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;

endpackage

FILE: src/rde_divider.sv
// ----------------------------------------------------------------------------
// rde_divider
// Restoring divider: one quotient bit per cycle, dividing the running
// quotient by the radix.
// ----------------------------------------------------------------------------
module rde_divider #(
  parameter int VALUE_WIDTH = rde_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [VALUE_WIDTH-1:0]          dividend,
  input  logic [rde_pkg::RADIX_BITS-1:0]  base,
  output logic                            done,
  output logic [VALUE_WIDTH-1:0]          quotient,
  output logic [rde_pkg::DIGIT_BITS-1:0]  remainder
);

  localparam int CW = $clog2(VALUE_WIDTH);

  logic                           busy;
  logic [CW-1:0]                  cnt;
  logic [rde_pkg::DIGIT_BITS:0]   rem_sh;
  logic [rde_pkg::DIGIT_BITS:0]   diff;
  logic                           ge;

  // Shift in the next dividend bit and try to subtract the base.
  assign rem_sh = {remainder, quotient[VALUE_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, base};
  assign ge     = (rem_sh >= {1'b0, base});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(VALUE_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[VALUE_WIDTH-2:0], ge};
      remainder <= ge ? diff[rde_pkg::DIGIT_BITS-1:0] : rem_sh[rde_pkg::DIGIT_BITS-1:0];
    end
  end

endmodule

FILE: src/rde_digit_stack.sv
// ----------------------------------------------------------------------------
// rde_digit_stack
// Digit storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rde_digit_stack #(
  parameter int STACK_DEPTH = rde_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(STACK_DEPTH)-1:0]      wr_addr,
  input  logic [rde_pkg::DIGIT_BITS-1:0]      wr_data,
  input  logic                                rd_en,
  input  logic [$clog2(STACK_DEPTH)-1:0]      rd_addr,
  output logic [rde_pkg::DIGIT_BITS-1:0]      rd_data
);

  logic [rde_pkg::DIGIT_BITS-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/radix_digit_emitter_unit.sv
// ----------------------------------------------------------------------------
// radix_digit_emitter_unit
// Converts an unsigned value to the programmed radix by repeated division,
// stacks the remainders and emits the digits most significant first.
// ----------------------------------------------------------------------------
//
//   channel  | signals                         | direction | transaction
//   ---------+---------------------------------+-----------+---------------------
//   input    | in_valid, in_ready, value       | in        | one value to convert
//   output   | out_valid, out_ready, digit,    | out       | one digit, last flag
//            | last_digit                      |           |
//   config   | radix_we, radix_wdata           | in        | radix write, no wait
//
// Each digit costs one divider launch, a full bit-serial division and one
// push; each digit then drains through a stack read, an output load and
// the output transaction, which output stalls can hold.
// Reset: synchronous, active high; radix returns to 2, the stack is empty.
// Stalls: one value at a time; in_ready is high only while idle. A stalled
// output holds the digit until taken.
//
module radix_digit_emitter_unit #(
  parameter int VALUE_WIDTH = rde_pkg::DEFAULT_VALUE_WIDTH,
  parameter int STACK_DEPTH = rde_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rde_pkg::VALUE_BITS-1:0]  value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rde_pkg::DIGIT_BITS-1:0]  digit,
  output logic                            last_digit,
  input  logic                            radix_we,
  input  logic [rde_pkg::RADIX_BITS-1:0]  radix_wdata
);

  localparam int PW   = $clog2(STACK_DEPTH);
  localparam int CNTW = $clog2(STACK_DEPTH + 1);
  localparam int EXTW = VALUE_WIDTH + rde_pkg::VALUE_BITS;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_START    = 3'd1;
  localparam logic [2:0] ST_DIV      = 3'd2;
  localparam logic [2:0] ST_DRAIN_RD = 3'd3;
  localparam logic [2:0] ST_LOAD     = 3'd4;
  localparam logic [2:0] ST_EMIT     = 3'd5;

  logic [2:0]                       state;
  logic [rde_pkg::RADIX_BITS-1:0]   radix;
  logic [rde_pkg::RADIX_BITS-1:0]   base;
  logic [VALUE_WIDTH-1:0]           quotient;
  logic [CNTW-1:0]                  top;
  logic [CNTW-1:0]                  top_m1;
  logic [EXTW-1:0]                  value_ext;
  logic [VALUE_WIDTH-1:0]           value_in;

  logic                             div_start;
  logic                             div_done;
  logic [VALUE_WIDTH-1:0]           div_quotient;
  logic [rde_pkg::DIGIT_BITS-1:0]   div_remainder;

  logic                             wr_en;
  logic [PW-1:0]                    wr_addr;
  logic [rde_pkg::DIGIT_BITS-1:0]   wr_data;
  logic                             rd_en;
  logic [rde_pkg::DIGIT_BITS-1:0]   rd_data;

  logic                             in_fire;
  logic                             stack_room;

  // Keep only the low VALUE_WIDTH bits of the port, zero-extend when wider.
  assign value_ext = {{VALUE_WIDTH{1'b0}}, value};
  assign value_in  = value_ext[VALUE_WIDTH-1:0];

  // Radix zero or one runs as radix 2 so the division always ends.
  assign base = (radix < rde_pkg::RADIX_MIN) ? rde_pkg::RADIX_MIN : radix;

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = (state == ST_EMIT);
  assign top_m1     = top - 1'b1;
  assign stack_room = (top < CNTW'(STACK_DEPTH));

  assign div_start  = (state == ST_START);
  assign rd_en      = (state == ST_DRAIN_RD);

  // Push a zero digit for a zero value; otherwise push each remainder while
  // the stack has room, and drop it once full.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = top[PW-1:0];
    wr_data = div_remainder;
    if (in_fire && (value_in == '0)) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '0;
    end else if ((state == ST_DIV) && div_done && stack_room) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rde_pkg::RADIX_RESET;
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      top   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (value_in == '0) begin
              top   <= CNTW'(1);
              state <= ST_DRAIN_RD;
            end else begin
              top   <= '0;
              state <= ST_START;
            end
          end
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          // Advance the quotient; stop dividing once it reaches zero.
          if (div_done) begin
            if (stack_room) begin
              top <= top + 1'b1;
            end
            state <= (div_quotient == '0) ? ST_DRAIN_RD : ST_START;
          end
        end
        ST_DRAIN_RD: begin
          top   <= top_m1;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_ready) begin
            state <= (top == '0) ? ST_IDLE : ST_DRAIN_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Running quotient between divisions.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      quotient <= value_in;
    end else if ((state == ST_DIV) && div_done) begin
      quotient <= div_quotient;
    end
  end

  // Output register: hold the popped digit until the transaction completes.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      digit      <= rd_data;
      last_digit <= (top == '0);
    end
  end

  rde_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (quotient),
    .base      (base),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  rde_digit_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (top_m1[PW-1:0]),
    .rd_data (rd_data)
  );

endmodule
